// File: sv/twq_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// twq_pkg: shared types and constants for the tick wakeup queue
// Request and reply codes, the queue entry held by each cell, and the
// command that the controller sends along the row of cells.
// ---------------------------------------------------------------------------
package twq_pkg;

  // Number of queue cells, one per task slot
  localparam int TASK_SLOTS = 64;
  // Field widths fixed by the interface
  localparam int ID_W       = 6;
  localparam int TIME_W     = 32;
  localparam int KIND_W     = 2;
  // Task ids that the id field can name
  localparam int ID_SLOTS   = 2 ** ID_W;

  typedef enum logic [KIND_W-1:0] {
    REQ_TICK  = 2'd0,
    REQ_TIME  = 2'd1,
    REQ_DELAY = 2'd2,
    REQ_UNTIL = 2'd3
  } req_kind_t;

  typedef enum logic [KIND_W-1:0] {
    REPLY_RELEASED = 2'd0,
    REPLY_TIME     = 2'd1,
    REPLY_ERROR    = 2'd2
  } reply_kind_t;

  // One queue entry
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] wake;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2
  } cell_op_t;

  // Command broadcast to every cell
  typedef struct packed {
    cell_op_t          op;
    logic [TIME_W-1:0] wake;
    logic [ID_W-1:0]   id;
  } cell_cmd_t;

endpackage
`default_nettype wire

// File: sv/twq_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// twq_cell: one cell of the sorted wakeup queue
// Holds one entry. On insert it keeps its entry, takes the new one, or takes
// its left neighbor's; on pop it takes its right neighbor's entry.
// ---------------------------------------------------------------------------
module twq_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_cell,
  input  wire twq_pkg::cell_cmd_t cmd,
  input  wire twq_pkg::entry_t   left_entry,
  input  wire logic              left_yield,
  input  wire twq_pkg::entry_t   right_entry,
  output twq_pkg::entry_t        entry,
  output logic                   yield
);

  logic                       valid;
  logic [twq_pkg::TIME_W-1:0] wake;
  logic [twq_pkg::ID_W-1:0]   id;

  assign entry = '{valid: valid, wake: wake, id: id};

  // Give way to a new entry: the head only to a strictly earlier time,
  // the others to an equal or earlier time
  always_comb begin
    if (!valid) begin
      yield = 1'b1;
    end else if (head_cell) begin
      yield = (cmd.wake < wake);
    end else begin
      yield = (wake >= cmd.wake);
    end
  end

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (cmd.op)
        twq_pkg::CELL_INSERT: begin
          if (left_yield) begin
            valid <= left_entry.valid;
          end else if (yield) begin
            valid <= 1'b1;
          end
        end
        twq_pkg::CELL_POP: valid <= right_entry.valid;
        default: ;
      endcase
    end
  end

  // Move payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      twq_pkg::CELL_INSERT: begin
        if (left_yield) begin
          wake <= left_entry.wake;
          id   <= left_entry.id;
        end else if (yield) begin
          wake <= cmd.wake;
          id   <= cmd.id;
        end
      end
      twq_pkg::CELL_POP: begin
        wake <= right_entry.wake;
        id   <= right_entry.id;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/tick_wakeup_queue_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tick_wakeup_queue_core: tick counter with a time-ordered wakeup queue
// Keeps the tick count and a row of cells that hold sleeping tasks sorted
// by wakeup time, the earliest in the first cell.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready): req_type, task_id, tick_count.
//   A tick advances the count (saturating) and releases the head task if it
//   is due. A time request returns the count. A delay queues the task at
//   count plus tick_count (saturating); a delay-until at tick_count.
//   Reply channel (rsp_valid/rsp_ready): reply_kind, woken_task, time_now.
//   A tick with nothing due and an accepted delay give no reply; a delay for
//   a task already queued, or into a full queue, gives an error reply.
//   Each item is handled in order: the request is registered and its wakeup
//   time worked out, then every cell compares against it in parallel and
//   the row shifts by one place (insert or pop).
//   The reply is loaded when the item finishes and waits in the output
//   register; while the receiver stalls, the next item may be accepted but,
//   if it has a reply, is held in ST_EXEC until the reply register is free.
//   Reset empties the queue and clears the count; no sweep is needed.
// ---------------------------------------------------------------------------
module tick_wakeup_queue_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       req_valid,
  output logic                            req_ready,
  input  wire logic [twq_pkg::KIND_W-1:0] req_type,
  input  wire logic [twq_pkg::ID_W-1:0]   task_id,
  input  wire logic [twq_pkg::TIME_W-1:0] tick_count,
  output logic                            rsp_valid,
  input  wire logic                       rsp_ready,
  output logic [twq_pkg::KIND_W-1:0]      reply_kind,
  output logic [twq_pkg::ID_W-1:0]        woken_task,
  output logic [twq_pkg::TIME_W-1:0]      time_now
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t                     state;
  twq_pkg::req_kind_t         req_kind;
  logic [twq_pkg::ID_W-1:0]   req_id;
  logic [twq_pkg::TIME_W-1:0] req_wake;
  logic [twq_pkg::TIME_W-1:0] now_ticks;
  logic [twq_pkg::ID_SLOTS-1:0] queued_flags;

  twq_pkg::entry_t   entries [twq_pkg::TASK_SLOTS];
  logic              yields  [twq_pkg::TASK_SLOTS];
  twq_pkg::cell_cmd_t cmd;

  logic                       req_fire;
  logic [twq_pkg::TIME_W:0]   delay_sum;
  logic [twq_pkg::TIME_W:0]   tick_sum;
  logic [twq_pkg::TIME_W-1:0] wake_next;
  logic [twq_pkg::TIME_W-1:0] now_next;

  logic                       has_result;
  logic                       finish;
  logic                       do_pop;
  logic                       do_insert;
  logic                       reject;
  twq_pkg::reply_kind_t       res_kind;
  logic [twq_pkg::ID_W-1:0]   res_id;

  assign req_ready = (state == ST_IDLE);
  assign req_fire  = req_valid && req_ready;

  // Saturating sums for the wakeup time and the counter
  assign delay_sum = {1'b0, now_ticks} + {1'b0, tick_count};
  assign tick_sum  = {1'b0, now_ticks} + {{twq_pkg::TIME_W{1'b0}}, 1'b1};
  assign wake_next = delay_sum[twq_pkg::TIME_W] ? '1 : delay_sum[twq_pkg::TIME_W-1:0];
  assign now_next  = tick_sum[twq_pkg::TIME_W] ? '1 : tick_sum[twq_pkg::TIME_W-1:0];

  // Decide the outcome of the registered request
  always_comb begin
    reject     = (32'(req_id) >= twq_pkg::TASK_SLOTS) || queued_flags[req_id] ||
                 entries[twq_pkg::TASK_SLOTS-1].valid;
    has_result = 1'b0;
    do_pop     = 1'b0;
    do_insert  = 1'b0;
    res_kind   = twq_pkg::REPLY_TIME;
    res_id     = '0;
    unique case (req_kind) inside
      twq_pkg::REQ_TICK: begin
        if (entries[0].valid && (entries[0].wake <= now_ticks)) begin
          do_pop     = 1'b1;
          has_result = 1'b1;
          res_kind   = twq_pkg::REPLY_RELEASED;
          res_id     = entries[0].id;
        end
      end
      twq_pkg::REQ_TIME: begin
        has_result = 1'b1;
      end
      twq_pkg::REQ_DELAY, twq_pkg::REQ_UNTIL: begin
        if (reject) begin
          has_result = 1'b1;
          res_kind   = twq_pkg::REPLY_ERROR;
          res_id     = req_id;
        end else begin
          do_insert = 1'b1;
        end
      end
      default: ;
    endcase
    finish = (state == ST_EXEC) && (!has_result || !rsp_valid || rsp_ready);
  end

  // Broadcast the row command
  always_comb begin
    cmd.op   = twq_pkg::CELL_HOLD;
    cmd.wake = req_wake;
    cmd.id   = req_id;
    if (finish && do_pop) begin
      cmd.op = twq_pkg::CELL_POP;
    end else if (finish && do_insert) begin
      cmd.op = twq_pkg::CELL_INSERT;
    end
  end

  // Row of queue cells, head first
  for (genvar i = 0; i < twq_pkg::TASK_SLOTS; i++) begin : g_cell
    twq_pkg::entry_t left_entry;
    twq_pkg::entry_t right_entry;
    logic            left_yield;

    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_yield = 1'b0;
    end else begin : g_body
      assign left_entry = entries[i-1];
      assign left_yield = yields[i-1];
    end

    if (i == twq_pkg::TASK_SLOTS - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_link
      assign right_entry = entries[i+1];
    end

    twq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .head_cell   ((i == 0) ? 1'b1 : 1'b0),
      .cmd         (cmd),
      .left_entry  (left_entry),
      .left_yield  (left_yield),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .yield       (yields[i])
    );
  end

  // Sequence requests, hold the counter and the reply register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      now_ticks    <= '0;
      queued_flags <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            state <= ST_EXEC;
            if (twq_pkg::req_kind_t'(req_type) == twq_pkg::REQ_TICK) begin
              now_ticks <= now_next;
            end
          end
        end
        ST_EXEC: begin
          if (finish) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (finish && do_pop) begin
        queued_flags[entries[0].id] <= 1'b0;
      end
      if (finish && do_insert) begin
        queued_flags[req_id] <= 1'b1;
      end

      // Load the reply, or drop it once accepted
      if (finish && has_result) begin
        rsp_valid  <= 1'b1;
        reply_kind <= res_kind;
        woken_task <= res_id;
        time_now   <= now_ticks;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_kind <= twq_pkg::req_kind_t'(req_type);
      req_id   <= task_id;
      if (twq_pkg::req_kind_t'(req_type) == twq_pkg::REQ_DELAY) begin
        req_wake <= wake_next;
      end else begin
        req_wake <= tick_count;
      end
    end
  end

endmodule
`default_nettype wire

// File: tb/tick_wakeup_queue_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tick_wakeup_queue_checker: reply predictor and scoreboard
// Watches both channels of the wakeup queue core. Every accepted request is
// run through a local copy of the tick count and the sleeping-task list to
// work out the reply it causes, if any. Every accepted reply is compared
// field by field with the oldest outstanding expectation.
// ---------------------------------------------------------------------------
module tick_wakeup_queue_checker
  import twq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  input  wire logic              req_ready,
  input  wire logic [KIND_W-1:0] req_type,
  input  wire logic [ID_W-1:0]   task_id,
  input  wire logic [TIME_W-1:0] tick_count,
  input  wire logic              rsp_valid,
  input  wire logic              rsp_ready,
  input  wire logic [KIND_W-1:0] reply_kind,
  input  wire logic [ID_W-1:0]   woken_task,
  input  wire logic [TIME_W-1:0] time_now,
  output int                     fail_count,
  output int                     pending
);

  typedef struct packed {
    logic [TIME_W-1:0] wake;
    logic [ID_W-1:0]   id;
  } sleeper_t;

  typedef struct packed {
    reply_kind_t       kind;
    logic [ID_W-1:0]   slot;
    logic [TIME_W-1:0] stamp;
  } reply_t;

  logic [TIME_W-1:0] clock_ticks;
  // Sleeping tasks, earliest wakeup first
  sleeper_t          sleepers[$];
  logic [ID_SLOTS-1:0] asleep;
  reply_t            expected_replies[$];

  // Apply one request to the local state and queue the reply it causes
  task automatic serve_request(input req_kind_t kind, input logic [ID_W-1:0] id,
                               input logic [TIME_W-1:0] ticks);
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] wake;
    sleeper_t          head;
    int                pos;
    case (kind)
      REQ_TICK: begin
        if (clock_ticks != '1) clock_ticks++;
        // release the head only when it is due
        if (sleepers.size() > 0 && sleepers[0].wake <= clock_ticks) begin
          head = sleepers.pop_front();
          asleep[head.id] = 1'b0;
          expected_replies.push_back('{REPLY_RELEASED, head.id, clock_ticks});
        end
      end
      REQ_TIME: begin
        expected_replies.push_back('{REPLY_TIME, '0, clock_ticks});
      end
      default: begin
        // saturate the relative wakeup time
        if (kind == REQ_DELAY) begin
          sum  = {1'b0, clock_ticks} + {1'b0, ticks};
          wake = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        end else begin
          wake = ticks;
        end
        if (int'(id) >= TASK_SLOTS || asleep[id] || sleepers.size() >= TASK_SLOTS) begin
          expected_replies.push_back('{REPLY_ERROR, id, clock_ticks});
        end else begin
          // go in front of equal times, but ahead of the head only when strictly earlier
          if (sleepers.size() == 0 || wake < sleepers[0].wake) begin
            pos = 0;
          end else begin
            pos = 1;
            while (pos < sleepers.size() && wake > sleepers[pos].wake) pos++;
          end
          sleepers.insert(pos, '{wake, id});
          asleep[id] = 1'b1;
        end
      end
    endcase
  endtask

  // Compare replies first: a reply accepted now belongs to an earlier request
  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      clock_ticks = '0;
      asleep      = '0;
      sleepers.delete();
      expected_replies.delete();
      fail_count  = 0;
      pending     = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected reply: reply_kind %0d woken_task %0d time_now %0d",
                 reply_kind, woken_task, time_now);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          if (reply_kind !== want.kind) begin
            $error("reply_kind: expected %0d, got %0d", want.kind, reply_kind);
            fail_count++;
          end
          if (woken_task !== want.slot) begin
            $error("woken_task: expected %0d, got %0d", want.slot, woken_task);
            fail_count++;
          end
          if (time_now !== want.stamp) begin
            $error("time_now: expected %0d, got %0d", want.stamp, time_now);
            fail_count++;
          end
        end
      end
      if (req_valid && req_ready) begin
        serve_request(req_kind_t'(req_type), task_id, tick_count);
      end
      pending = expected_replies.size();
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: stimulus and verdict for tick_wakeup_queue_core
// Drives ticks, time queries and both delay kinds in bursts while the reply
// side stalls on its own pattern. A short directed run covers ordering of
// equal wakeup times, saturation and rejects; the random run mixes small
// delays that wake soon with a few far ones, and once fills every slot.
// ---------------------------------------------------------------------------
module tb;
  import twq_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int RESET_CYCLES = 8;
  localparam int ITEM_TARGET = 950;
  localparam int FILL_AT     = 400;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 200;

  // Reply-side stall modes
  localparam int READY_ALWAYS = 0;
  localparam int READY_COIN   = 1;
  localparam int READY_SPARSE = 2;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              req_valid  = 1'b0;
  logic [KIND_W-1:0] req_type   = REQ_TICK;
  logic [ID_W-1:0]   task_id    = '0;
  logic [TIME_W-1:0] tick_count = '0;
  logic              rsp_ready  = 1'b0;
  logic              req_ready;
  logic              rsp_valid;
  logic [KIND_W-1:0] reply_kind;
  logic [ID_W-1:0]   woken_task;
  logic [TIME_W-1:0] time_now;
  int                fail_count;
  int                pending;

  int                items_sent  = 0;
  logic [TIME_W-1:0] ticks_sent  = '0;
  int                burst_left  = 0;
  int                ready_mode  = READY_ALWAYS;
  int                ready_left  = 0;
  int                idle_cycles = 0;

  always #CLK_HALF clk = ~clk;

  tick_wakeup_queue_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_type   (req_type),
    .task_id    (task_id),
    .tick_count (tick_count),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .reply_kind (reply_kind),
    .woken_task (woken_task),
    .time_now   (time_now)
  );

  tick_wakeup_queue_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_type   (req_type),
    .task_id    (task_id),
    .tick_count (tick_count),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .reply_kind (reply_kind),
    .woken_task (woken_task),
    .time_now   (time_now),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Hold one item until accepted, then continue the burst or pause
  task automatic send_request(input req_kind_t kind, input logic [ID_W-1:0] id,
                              input logic [TIME_W-1:0] ticks);
    req_valid  <= 1'b1;
    req_type   <= kind;
    task_id    <= id;
    tick_count <= ticks;
    do @(negedge clk); while (!req_ready);
    @(posedge clk);
    items_sent++;
    if (kind == REQ_TICK) ticks_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 19);
      if ($urandom_range(0, 99) >= 30) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  // Stall the reply side in phases of steady, coin-flip and sparse ready
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(READY_ALWAYS, READY_SPARSE);
      ready_left = $urandom_range(8, 40);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      READY_ALWAYS: rsp_ready <= 1'b1;
      READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
      default:      rsp_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tick_wakeup_queue_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int                order [TASK_SLOTS];
    int                i;
    int                pick;
    int                swap;
    int                roll;
    logic [TIME_W-1:0] ticks;
    logic [ID_W-1:0]   id;
    bit                filled;

    filled = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty queue, saturation, rejects and equal-time ordering
    send_request(REQ_TIME, 6'd0, '0);
    send_request(REQ_TICK, 6'd0, '0);
    send_request(REQ_DELAY, 6'd63, '1);
    send_request(REQ_DELAY, 6'd63, 32'd1);
    send_request(REQ_UNTIL, 6'd0, '0);
    send_request(REQ_UNTIL, 6'd1, '0);
    send_request(REQ_UNTIL, 6'd2, '0);
    send_request(REQ_UNTIL, 6'd3, 32'd5);
    send_request(REQ_DELAY, 6'd4, 32'd3);
    send_request(REQ_UNTIL, 6'd5, '1);
    send_request(REQ_UNTIL, 6'd42, 32'hAAAA_5555);
    repeat (6) send_request(REQ_TICK, 6'd0, '0);
    send_request(REQ_TIME, 6'd0, '0);
    send_request(REQ_DELAY, 6'd21, '0);
    send_request(REQ_UNTIL, 6'd7, 32'd1);
    send_request(REQ_TICK, 6'd0, '0);
    send_request(REQ_TICK, 6'd0, '0);

    // Random: mostly near wakeups so the queue keeps turning over
    while (items_sent < ITEM_TARGET) begin
      if (!filled && items_sent >= FILL_AT) begin
        filled = 1'b1;
        // put every slot to sleep in random order, then overflow and drain
        for (i = 0; i < TASK_SLOTS; i++) order[i] = i;
        for (i = TASK_SLOTS - 1; i > 0; i--) begin
          pick        = $urandom_range(0, i);
          swap        = order[i];
          order[i]    = order[pick];
          order[pick] = swap;
        end
        for (i = 0; i < TASK_SLOTS; i++) begin
          if ($urandom_range(0, 1) != 0) begin
            send_request(REQ_DELAY, ID_W'(order[i]), $urandom_range(0, 60));
          end else begin
            send_request(REQ_UNTIL, ID_W'(order[i]), ticks_sent + $urandom_range(0, 60));
          end
        end
        send_request(REQ_DELAY, ID_W'($urandom_range(0, ID_SLOTS - 1)), '0);
        send_request(REQ_UNTIL, ID_W'($urandom_range(0, ID_SLOTS - 1)), ticks_sent);
        repeat (90) begin
          if ($urandom_range(0, 9) == 0) send_request(REQ_TIME, ID_W'($urandom), '0);
          else send_request(REQ_TICK, ID_W'($urandom), $urandom);
        end
      end else begin
        roll = $urandom_range(0, 99);
        id   = ID_W'($urandom_range(0, ID_SLOTS - 1));
        if (roll < 40) begin
          send_request(REQ_TICK, id, $urandom);
        end else if (roll < 50) begin
          send_request(REQ_TIME, id, $urandom);
        end else if (roll < 75) begin
          roll = $urandom_range(0, 99);
          if (roll < 2)      ticks = $urandom;
          else if (roll < 4) ticks = '1 - $urandom_range(0, 3);
          else               ticks = $urandom_range(0, 24);
          send_request(REQ_DELAY, id, ticks);
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 2)                        ticks = $urandom;
          else if (roll < 8 && ticks_sent > 10) ticks = ticks_sent - $urandom_range(0, 10);
          else                                  ticks = ticks_sent + $urandom_range(0, 24);
          send_request(REQ_UNTIL, id, ticks);
        end
      end
    end
    req_valid <= 1'b0;

    // Drain outstanding replies, then allow late or stray replies to show up
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tick_wakeup_queue_core: match");
    end else begin
      $display("tick_wakeup_queue_core: mismatch");
    end
    $finish;
  end

endmodule
